>>> rtl/core/sang_pkg.sv
// Shared types, constants and helper functions for the shuffled alphabet
// name generator. Depends on nothing; imported by the top level.
`timescale 1ns / 1ps
`default_nettype none

package sang_pkg;

	// Input item kinds.
	localparam logic ACT_INIT = 1'b0;
	localparam logic ACT_NAME = 1'b1;

	// Table layout in the shared memory: letters at 0..51, symbols at 64..127.
	localparam int NUM_LETTERS = 52;
	localparam int NUM_SYMBOLS = 64;
	localparam int TBL_AW      = 7;
	localparam int TBL_DEPTH   = 128;

	// Bound on regenerations of one reserved name.
	localparam int GUARD_LIMIT = 64;

	// Characters of the reserved words.
	localparam logic [7:0] CH_D = 8'h64;
	localparam logic [7:0] CH_F = 8'h66;
	localparam logic [7:0] CH_I = 8'h69;
	localparam logic [7:0] CH_N = 8'h6e;
	localparam logic [7:0] CH_O = 8'h6f;
	localparam logic [7:0] CH_R = 8'h72;

	typedef logic [TBL_AW-1:0] tbl_addr_t;
	typedef logic [7:0]        char_t;

	// Identity contents of the table memory; bit 6 selects the symbol set.
	function automatic char_t id_char(input tbl_addr_t addr);
		logic [5:0] i;
		char_t      c;
		i = addr[5:0];
		if (!addr[6]) begin
			if (i < 6'd26) c = 8'h41 + {2'b00, i};
			else           c = 8'h61 + {2'b00, i - 6'd26};
		end else begin
			if (i < 6'd10)      c = 8'h30 + {2'b00, i};
			else if (i < 6'd36) c = 8'h41 + {2'b00, i - 6'd10};
			else if (i < 6'd62) c = 8'h61 + {2'b00, i - 6'd36};
			else if (i == 6'd62) c = 8'h2d;
			else                 c = 8'h5f;
		end
		return c;
	endfunction

	// One xorshift64 step with shifts 13, 7 and 17.
	function automatic logic [63:0] xs_next(input logic [63:0] s);
		logic [63:0] t;
		t = s ^ (s << 13);
		t = t ^ (t >> 7);
		t = t ^ (t << 17);
		return t;
	endfunction

	// One radix-16 step of division by 13: val = rem*16 + nibble, rem < 13.
	// Returns {quotient digit, new remainder}. The reciprocal 79/1024 is exact
	// for every value below 341.
	function automatic logic [7:0] div13_step(input logic [3:0] rem, input logic [3:0] nib);
		logic [7:0]  val;
		logic [13:0] prod;
		logic [3:0]  qd;
		logic [7:0]  r;
		val  = {rem, nib};
		prod = 14'(val) * 14'd79;
		qd   = prod[13:10];
		r    = val - ({4'b0000, qd} * 8'd13);
		return {qd, r[3:0]};
	endfunction

endpackage

`default_nettype wire

>>> rtl/core/shuffled_alphabet_name_generator_top.sv
// An init item runs an identity load of all 128 table entries, then 52 letter swaps
// through the radix-16 mod-13 unit and 64 symbol swaps, then one acknowledgement beat.
// A name item raises its value past the skip list, divides it and fetches and checks
// its n characters before sending them as n beats; each retry either steps past a
// value or records one in the skip list and raises the value again.
// One item at a time; busy is high from acceptance until the last beat has gone out.
// Reset clears control and sets the seed to one; tables read as identity until an init.
// Top level of the shuffled alphabet name generator; imports sang_pkg.
// Holds the table memory, the mod-13 divider, the skip lists and the sequencer.
`timescale 1ns / 1ps
`default_nettype none

module shuffled_alphabet_name_generator_top import sang_pkg::*; #(
	parameter int SKIP_DEPTH     = 4,
	parameter int MAX_NAME_CHARS = 6
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic        action,
	input  wire logic [30:0] name_index,
	input  wire logic        use_shuffled,
	input  wire logic        cfg_we,
	input  wire logic [63:0] cfg_wdata,
	output logic             strobe,
	output logic [7:0]       name_char,
	output logic             last_char,
	output logic             skip_overflow,
	output logic             init_done
);

	localparam int IW = (SKIP_DEPTH > 1) ? $clog2(SKIP_DEPTH) : 1;
	localparam int CW = $clog2(SKIP_DEPTH + 1);
	localparam int NW = $clog2(MAX_NAME_CHARS + 1);
	localparam int PW = $clog2(MAX_NAME_CHARS);

	localparam logic [4:0] S_IDLE   = 5'd0;
	localparam logic [4:0] S_LOAD   = 5'd1;
	localparam logic [4:0] S_SHNEXT = 5'd2;
	localparam logic [4:0] S_SHDIV  = 5'd3;
	localparam logic [4:0] S_RDK    = 5'd4;
	localparam logic [4:0] S_RDR    = 5'd5;
	localparam logic [4:0] S_WRK    = 5'd6;
	localparam logic [4:0] S_WRR    = 5'd7;
	localparam logic [4:0] S_ACK    = 5'd8;
	localparam logic [4:0] S_RAISE  = 5'd9;
	localparam logic [4:0] S_NDIV   = 5'd10;
	localparam logic [4:0] S_LEAD   = 5'd11;
	localparam logic [4:0] S_DIG    = 5'd12;
	localparam logic [4:0] S_FETCH  = 5'd13;
	localparam logic [4:0] S_FWAIT  = 5'd14;
	localparam logic [4:0] S_CHECK  = 5'd15;
	localparam logic [4:0] S_EMIT   = 5'd16;

	logic [4:0]  state_q;
	logic [63:0] seed_q;
	logic [63:0] prng_q;
	logic        tbl_valid_q;
	logic        sym_phase_q;
	logic [6:0]  k_q;
	char_t       tmp_q;

	// Table memory and its registered read port.
	char_t       mem [TBL_DEPTH];
	char_t       mem_rd_q;
	logic        mem_we;
	tbl_addr_t   mem_wa;
	char_t       mem_wd;
	tbl_addr_t   rd_addr;

	// Radix-16 divider by 13.
	logic [63:0] div_x_q;
	logic [3:0]  div_r_q;
	logic [31:0] div_q_q;
	logic [3:0]  div_cnt_q;
	logic [7:0]  div_step;

	// Name generation.
	logic [30:0] idx_q;
	logic        use_sh_q;
	logic [31:0] v_q;
	logic [31:0] v_inc;
	logic [CW-1:0] j_q;
	logic [6:0]  guard_q;
	logic        ovf_q;
	logic [31:0] skip_list_q [2][SKIP_DEPTH];
	logic [CW-1:0] skip_cnt_q [2];
	logic [31:0] w_q;
	logic [31:0] w_dec;
	logic [NW-1:0] n_q;
	logic [NW-1:0] p_q;
	tbl_addr_t   chidx_q [MAX_NAME_CHARS];
	char_t       buf_q [MAX_NAME_CHARS];
	logic        fetch_s1;
	logic [PW-1:0] fpos_s1;
	tbl_addr_t   faddr_s1;

	logic [5:0]  rsel;
	logic [1:0]  crt_t;
	logic        reserved;
	logic        listed;
	logic        emit_last;

	assign busy   = (state_q != S_IDLE);
	assign div_step = div13_step(div_r_q, div_x_q[63:60]);
	assign v_inc  = v_q + 32'd1;
	assign w_dec  = w_q - 32'd1;
	assign emit_last = (p_q == n_q - NW'(1));

	// Swap partner: letters combine s mod 4 and s mod 13, symbols take s mod 64.
	always_comb begin
		crt_t = prng_q[1:0] - div_r_q[1:0];
		if (sym_phase_q) rsel = prng_q[5:0];
		else             rsel = {2'b00, div_r_q} + ({4'b0000, crt_t} * 6'd13);
	end

	// Reserved word test and the search of the active skip list.
	always_comb begin
		reserved = 1'b0;
		if (n_q == NW'(2)) begin
			if (buf_q[0] == CH_D && buf_q[1] == CH_O) reserved = 1'b1;
			if (buf_q[0] == CH_I && (buf_q[1] == CH_F || buf_q[1] == CH_N)) reserved = 1'b1;
		end
		if (n_q == NW'(3) && buf_q[0] == CH_F && buf_q[1] == CH_O && buf_q[2] == CH_R)
			reserved = 1'b1;
		listed = 1'b0;
		for (int k = 0; k < SKIP_DEPTH; k++) begin
			if (CW'(k) < skip_cnt_q[use_sh_q] && skip_list_q[use_sh_q][k] == v_q)
				listed = 1'b1;
		end
	end

	// Memory address and write selection.
	always_comb begin
		mem_we  = 1'b0;
		mem_wa  = '0;
		mem_wd  = '0;
		rd_addr = '0;
		case (state_q)
			S_LOAD: begin
				mem_we = 1'b1;
				mem_wa = k_q;
				mem_wd = id_char(k_q);
			end
			S_RDK:   rd_addr = {sym_phase_q, k_q[5:0]};
			S_RDR:   rd_addr = {sym_phase_q, rsel};
			S_WRK: begin
				mem_we = 1'b1;
				mem_wa = {sym_phase_q, k_q[5:0]};
				mem_wd = mem_rd_q;
			end
			S_WRR: begin
				mem_we = 1'b1;
				mem_wa = {sym_phase_q, rsel};
				mem_wd = tmp_q;
			end
			S_FETCH: rd_addr = chidx_q[p_q[PW-1:0]];
			default: rd_addr = '0;
		endcase
	end

	// Table memory: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		mem_rd_q <= mem[rd_addr];
	end

	// Sequencer, divider, skip lists and result beats.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			seed_q        <= 64'd1;
			tbl_valid_q   <= 1'b0;
			skip_cnt_q[0] <= '0;
			skip_cnt_q[1] <= '0;
			fetch_s1      <= 1'b0;
			strobe        <= 1'b0;
		end else begin
			strobe   <= 1'b0;
			fetch_s1 <= (state_q == S_FETCH);
			fpos_s1  <= p_q[PW-1:0];
			faddr_s1 <= rd_addr;
			if (fetch_s1) begin
				buf_q[fpos_s1] <= (!use_sh_q || !tbl_valid_q) ? id_char(faddr_s1) : mem_rd_q;
			end
			if (cfg_we) seed_q <= cfg_wdata;

			case (state_q)
				S_IDLE: begin
					if (start) begin
						idx_q    <= name_index;
						use_sh_q <= use_shuffled;
						if (action == ACT_INIT) begin
							skip_cnt_q[0] <= '0;
							skip_cnt_q[1] <= '0;
							k_q           <= '0;
							state_q       <= S_LOAD;
						end else begin
							v_q     <= {1'b0, name_index};
							j_q     <= '0;
							guard_q <= '0;
							ovf_q   <= 1'b0;
							state_q <= S_RAISE;
						end
					end
				end
				// Identity sweep over the whole memory.
				S_LOAD: begin
					k_q <= k_q + 7'd1;
					if (k_q == 7'(TBL_DEPTH - 1)) begin
						k_q         <= '0;
						sym_phase_q <= 1'b0;
						prng_q      <= seed_q;
						tbl_valid_q <= 1'b1;
						state_q     <= S_SHNEXT;
					end
				end
				S_SHNEXT: begin
					prng_q <= xs_next(prng_q);
					if (!sym_phase_q) begin
						div_x_q   <= xs_next(prng_q);
						div_r_q   <= '0;
						div_cnt_q <= '0;
						state_q   <= S_SHDIV;
					end else begin
						state_q <= S_RDK;
					end
				end
				S_SHDIV, S_NDIV: begin
					div_x_q   <= div_x_q << 4;
					div_r_q   <= div_step[3:0];
					div_q_q   <= {div_q_q[27:0], div_step[7:4]};
					div_cnt_q <= div_cnt_q + 4'd1;
					if (div_cnt_q == 4'd15) state_q <= (state_q == S_SHDIV) ? S_RDK : S_LEAD;
				end
				S_RDK: state_q <= S_RDR;
				S_RDR: begin
					tmp_q   <= mem_rd_q;
					state_q <= S_WRK;
				end
				S_WRK: state_q <= S_WRR;
				S_WRR: begin
					k_q     <= k_q + 7'd1;
					state_q <= S_SHNEXT;
					if (!sym_phase_q && k_q == 7'(NUM_LETTERS - 1)) begin
						sym_phase_q <= 1'b1;
						k_q         <= '0;
					end else if (sym_phase_q && k_q == 7'(NUM_SYMBOLS - 1)) begin
						state_q <= S_ACK;
					end
				end
				S_ACK: begin
					strobe        <= 1'b1;
					name_char     <= '0;
					last_char     <= 1'b1;
					skip_overflow <= 1'b0;
					init_done     <= 1'b1;
					state_q       <= S_IDLE;
				end
				// Raise the value past each recorded skip value at or below it.
				S_RAISE: begin
					if (j_q < skip_cnt_q[use_sh_q]) begin
						if (skip_list_q[use_sh_q][j_q[IW-1:0]] <= v_q) v_q <= v_inc;
						j_q <= j_q + CW'(1);
					end else begin
						div_x_q   <= {34'd0, v_q[31:2]};
						div_r_q   <= '0;
						div_cnt_q <= '0;
						state_q   <= S_NDIV;
					end
				end
				// Leading letter: v mod 52 is four times (v/4 mod 13) plus v mod 4.
				S_LEAD: begin
					chidx_q[0] <= {1'b0, div_r_q, v_q[1:0]};
					w_q        <= div_q_q;
					n_q        <= NW'(1);
					state_q    <= S_DIG;
				end
				// Bijective base-64 digits, one per cycle.
				S_DIG: begin
					if (w_q != 32'd0 && n_q < NW'(MAX_NAME_CHARS)) begin
						chidx_q[n_q[PW-1:0]] <= {1'b1, w_dec[5:0]};
						w_q <= w_dec >> 6;
						n_q <= n_q + NW'(1);
					end else begin
						p_q     <= '0;
						state_q <= S_FETCH;
					end
				end
				S_FETCH: begin
					p_q <= p_q + NW'(1);
					if (emit_last) state_q <= S_FWAIT;
				end
				S_FWAIT: state_q <= S_CHECK;
				S_CHECK: begin
					if (reserved && guard_q < 7'(GUARD_LIMIT)) begin
						guard_q <= guard_q + 7'd1;
						if (!listed && skip_cnt_q[use_sh_q] < CW'(SKIP_DEPTH)) begin
							skip_list_q[use_sh_q][skip_cnt_q[use_sh_q][IW-1:0]] <= v_q;
							skip_cnt_q[use_sh_q] <= skip_cnt_q[use_sh_q] + CW'(1);
							v_q     <= {1'b0, idx_q};
							j_q     <= '0;
							state_q <= S_RAISE;
						end else begin
							if (!listed) ovf_q <= 1'b1;
							v_q       <= v_inc;
							div_x_q   <= {34'd0, v_inc[31:2]};
							div_r_q   <= '0;
							div_cnt_q <= '0;
							state_q   <= S_NDIV;
						end
					end else begin
						p_q     <= '0;
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					strobe        <= 1'b1;
					name_char     <= buf_q[p_q[PW-1:0]];
					last_char     <= emit_last;
					skip_overflow <= ovf_q;
					init_done     <= 1'b0;
					p_q           <= p_q + NW'(1);
					if (emit_last) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_ack_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && init_done |-> last_char && name_char == 8'd0 && !skip_overflow)
		else $error("init acknowledgement beat malformed");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted item did not raise busy");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last_char |-> !busy)
		else $error("last beat sent while still busy");

	a_skip_bound: assert property (@(posedge clk) disable iff (!arst_n)
		skip_cnt_q[0] <= CW'(SKIP_DEPTH) && skip_cnt_q[1] <= CW'(SKIP_DEPTH))
		else $error("skip list count beyond its depth");
`endif

endmodule

`default_nettype wire

>>> test/tb_top.sv
// Self-checking testbench for the shuffled alphabet name generator top level.
// Drives init and name commands, predicts every character beat, and compares.
// Depends on sang_pkg and shuffled_alphabet_name_generator_top only.
`timescale 1ns / 1ps

module tb_top;
	import sang_pkg::*;

	localparam int SKIP_N   = 4;
	localparam int STALL_MAX = 20000;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
		logic       ovf;
		logic       done;
	} name_beat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        action = ACT_NAME;
	logic [30:0] name_index = '0;
	logic        use_shuffled = 1'b0;
	logic        cfg_we = 1'b0;
	logic [63:0] cfg_wdata = '0;
	wire         busy, strobe, last_char, skip_overflow, init_done;
	wire  [7:0]  name_char;

	shuffled_alphabet_name_generator_top DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.action(action), .name_index(name_index), .use_shuffled(use_shuffled),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .strobe(strobe),
		.name_char(name_char), .last_char(last_char),
		.skip_overflow(skip_overflow), .init_done(init_done)
	);

	always #10 clk = ~clk;

	// Predictor state.
	logic [63:0] seed_reg;
	logic [7:0]  letter_tbl [NUM_LETTERS];
	logic [7:0]  symbol_tbl [NUM_SYMBOLS];
	logic [31:0] skip_vals  [2][SKIP_N];
	int          skip_cnt   [2];

	name_beat_t  pending_beats [$];
	int          mismatches = 0;
	int          idle_cycles = 0;
	bit          timed_out = 1'b0;
	bit          quiet_gaps = 1'b0;

	function automatic logic [7:0] plain_letter(int i);
		return (i < 26) ? 8'h41 + i : 8'h61 + i - 26;
	endfunction

	function automatic logic [7:0] plain_symbol(int i);
		if (i < 10) return 8'h30 + i;
		if (i < 36) return 8'h41 + i - 10;
		if (i < 62) return 8'h61 + i - 36;
		return (i == 62) ? 8'h2d : 8'h5f;
	endfunction

	function automatic void load_plain_tables();
		for (int k = 0; k < NUM_LETTERS; k++) letter_tbl[k] = plain_letter(k);
		for (int k = 0; k < NUM_SYMBOLS; k++) symbol_tbl[k] = plain_symbol(k);
	endfunction

	// Builds the name of value v from the chosen tables.
	function automatic int spell_name(logic [63:0] v, bit shuf, ref logic [7:0] buf_c[16]);
		int n;
		n = 0;
		buf_c[n++] = shuf ? letter_tbl[v % 52] : plain_letter(v % 52);
		v = v / 52;
		while (v > 0 && n < 15) begin
			v--;
			buf_c[n++] = shuf ? symbol_tbl[v % 64] : plain_symbol(v % 64);
			v = v / 64;
		end
		return n;
	endfunction

	function automatic bit is_keyword(ref logic [7:0] b[16], input int n);
		if (n == 2 && b[0] == CH_D && b[1] == CH_O) return 1;
		if (n == 2 && b[0] == CH_I && (b[1] == CH_F || b[1] == CH_N)) return 1;
		return n == 3 && b[0] == CH_F && b[1] == CH_O && b[2] == CH_R;
	endfunction

	function automatic logic [63:0] skip_raise(logic [63:0] v, int lst);
		for (int j = 0; j < skip_cnt[lst]; j++)
			if (skip_vals[lst][j] <= v) v++;
		return v;
	endfunction

	// Works out the beats of one command and updates the predictor state.
	function automatic void predict_command(bit act, logic [30:0] idx, bit shuf);
		logic [7:0]  b[16];
		logic [63:0] v, ps;
		int          n, r;
		bit          ovf, listed;
		logic [7:0]  t;
		name_beat_t  e;
		if (act == ACT_INIT) begin
			load_plain_tables();
			ps = seed_reg;
			for (int k = 0; k < NUM_LETTERS; k++) begin
				ps = ps ^ (ps << 13); ps = ps ^ (ps >> 7); ps = ps ^ (ps << 17);
				r = ps % 52;
				t = letter_tbl[k]; letter_tbl[k] = letter_tbl[r]; letter_tbl[r] = t;
			end
			for (int k = 0; k < NUM_SYMBOLS; k++) begin
				ps = ps ^ (ps << 13); ps = ps ^ (ps >> 7); ps = ps ^ (ps << 17);
				r = ps % 64;
				t = symbol_tbl[k]; symbol_tbl[k] = symbol_tbl[r]; symbol_tbl[r] = t;
			end
			skip_cnt[0] = 0;
			skip_cnt[1] = 0;
			pending_beats.push_back('{8'h00, 1'b1, 1'b0, 1'b1});
			return;
		end
		ovf = 0;
		v = skip_raise({33'd0, idx}, shuf);
		n = spell_name(v, shuf, b);
		for (int g = 0; g < GUARD_LIMIT && is_keyword(b, n); g++) begin
			listed = 0;
			for (int k = 0; k < skip_cnt[shuf]; k++)
				if (skip_vals[shuf][k] == v) listed = 1;
			if (listed) v++;
			else if (skip_cnt[shuf] < SKIP_N) begin
				skip_vals[shuf][skip_cnt[shuf]] = v[31:0];
				skip_cnt[shuf]++;
				v = skip_raise({33'd0, idx}, shuf);
			end else begin
				ovf = 1;
				v++;
			end
			n = spell_name(v, shuf, b);
		end
		if (n > 6) n = 6;
		for (int k = 0; k < n; k++) begin
			e = '{b[k], k + 1 == n, ovf, 1'b0};
			pending_beats.push_back(e);
		end
	endfunction

	// Compare every result beat against the oldest expectation.
	always @(posedge clk) begin
		name_beat_t got, want;
		if (arst_n && strobe) begin
			got = '{name_char, last_char, skip_overflow, init_done};
			if (pending_beats.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("Unexpected beat: %p", got);
			end else begin
				want = pending_beats.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Beat mismatch: expected %p, got %p", want, got);
				end
			end
		end
	end

	// Watchdog on cycles in which nothing moves.
	always @(posedge clk) begin
		if ((start && !busy) || strobe) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > STALL_MAX) begin
			$display("shuffled_alphabet_name_generator_top test failed");
			$finish;
		end
	end

	// Issue one command; unless quiet_gaps, start idles at random till accepted.
	task automatic issue(bit act, logic [30:0] idx, bit shuf);
		bit accepted;
		action <= act;
		name_index <= idx;
		use_shuffled <= shuf;
		start <= quiet_gaps || ($urandom_range(99) >= 38);
		do begin
			@(posedge clk);
			accepted = start && !busy;
			if (!accepted) start <= quiet_gaps || ($urandom_range(99) >= 38);
		end while (!accepted);
		predict_command(act, idx, shuf);
		start <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain_and_write(logic [63:0] seed);
		while (pending_beats.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= seed;
		@(posedge clk);
		cfg_we <= 1'b0;
		seed_reg = seed;
	endtask

	typedef struct {
		bit          act;
		logic [30:0] idx;
		bit          shuf;
	} stim_row_t;

	// Directed rows: extremes, keyword values, a listed value and the init.
	// With the plain tables 2681 spells "do", 2218 "if", 2634 "in", 182395 "for".
	stim_row_t directed [] = '{
		'{ACT_NAME, 31'd0, 1'b0}, '{ACT_NAME, 31'd51, 1'b1},
		'{ACT_NAME, 31'h7fffffff, 1'b0}, '{ACT_NAME, 31'd52, 1'b0},
		'{ACT_NAME, 31'd2681, 1'b0}, '{ACT_NAME, 31'd2681, 1'b0},
		'{ACT_NAME, 31'd2217, 1'b0}, '{ACT_NAME, 31'd2218, 1'b0},
		'{ACT_NAME, 31'd2633, 1'b0}, '{ACT_NAME, 31'd2679, 1'b0},
		'{ACT_NAME, 31'd182392, 1'b0}, '{ACT_INIT, 31'h7fffffff, 1'b1},
		'{ACT_NAME, 31'd2681, 1'b1}, '{ACT_NAME, 31'h7fffffff, 1'b1},
		'{ACT_NAME, 31'd2681, 1'b0}
	};

	initial begin
		name_beat_t first_beat;
		logic [30:0] idx;
		seed_reg = 64'd1;
		load_plain_tables();
		skip_cnt[0] = 0;
		skip_cnt[1] = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part; the predicted first beat is held to the known plain name.
		foreach (directed[i]) begin
			issue(directed[i].act, directed[i].idx, directed[i].shuf);
			if (i == 0) begin
				first_beat = pending_beats[0];
				if (first_beat.ch !== 8'h41) begin
					mismatches++;
					if (mismatches <= 10)
						$display("First name: expected %h, got %h", 8'h41, first_beat.ch);
				end
			end
		end

		// Random part over several seeds, zero and all-ones among them.
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: drain_and_write(64'd0);
				1: drain_and_write(64'hffff_ffff_ffff_ffff);
				default: drain_and_write({$urandom, $urandom});
			endcase
			quiet_gaps = (ph == 2);
			issue(ACT_INIT, 31'($urandom), 1'($urandom));
			for (int k = 0; k < 25; k++) begin
				case ($urandom_range(3))
					0: idx = 31'($urandom_range(2200, 2700));
					1: idx = 31'($urandom_range(182350, 182450));
					2: idx = 31'($urandom_range(3380));
					default: idx = 31'($urandom);
				endcase
				issue($urandom_range(30) == 0 ? ACT_INIT : ACT_NAME, idx, 1'($urandom));
			end
		end

		while (pending_beats.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (mismatches == 0)
			$display("shuffled_alphabet_name_generator_top test passed");
		else
			$display("shuffled_alphabet_name_generator_top test failed");
		$finish;
	end
endmodule
